FILE: src/pet_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pet_pkg
// Shared types and event codes for the pointer event tracker.
// ---------------------------------------------------------------------------
package pet_pkg;

    localparam int POINT_BITS = 12;
    localparam int CFG_BITS   = 13;

    // event classes
    localparam logic [15:0] EVT_KEY = 16'd1;
    localparam logic [15:0] EVT_REL = 16'd2;
    localparam logic [15:0] EVT_ABS = 16'd3;

    // axis and button codes
    localparam logic [15:0] AXIS_X        = 16'h0000;
    localparam logic [15:0] AXIS_Y        = 16'h0001;
    localparam logic [15:0] MT_POS_X      = 16'h0035;
    localparam logic [15:0] MT_POS_Y      = 16'h0036;
    localparam logic [15:0] MT_TRACK      = 16'h0039;
    localparam logic [15:0] BUTTON_LEFT   = 16'h0110;
    localparam logic [15:0] BUTTON_RIGHT  = 16'h0111;
    localparam logic [15:0] BUTTON_MIDDLE = 16'h0112;

    localparam logic signed [31:0] TRACK_RELEASE = -32'sd1;
    localparam logic signed [31:0] TRACK_PRESS   = 32'sd0;
    localparam logic signed [31:0] LEVEL_UP      = 32'sd0;
    localparam logic signed [31:0] LEVEL_DOWN    = 32'sd1;

    localparam logic [1:0] KEY_NONE  = 2'd0;
    localparam logic [1:0] KEY_LEFT  = 2'd1;
    localparam logic [1:0] KEY_RIGHT = 2'd2;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
    localparam logic [1:0] REG_AREA_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ROTATE_MODE = 2'd2;

    typedef struct packed {
        logic [31:0] acc_x;
        logic [31:0] acc_y;
        logic        pressed;
        logic [1:0]  key;
    } track_state_t;

    typedef struct packed {
        logic [POINT_BITS-1:0] point_x;
        logic [POINT_BITS-1:0] point_y;
        logic                  is_pressed;
        logic [1:0]            key_code;
    } report_t;

endpackage

FILE: src/pet_state.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pet_state
// Event decoder and tracking state: position accumulators, press, last key.
// ---------------------------------------------------------------------------
module pet_state
    import pet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               apply,
    input  logic [15:0]        event_type,
    input  logic [15:0]        event_code,
    input  logic signed [31:0] event_value,
    output track_state_t       state
);

    track_state_t state_reg;
    track_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        if (apply)
        begin
            if (event_type == EVT_REL)
            begin
                // 32-bit add wraps like the unsigned accumulator
                if (event_code == AXIS_X)
                    state_next.acc_x = state_reg.acc_x + event_value;
                else if (event_code == AXIS_Y)
                    state_next.acc_y = state_reg.acc_y + event_value;
            end
            else if (event_type == EVT_ABS)
            begin
                if (event_code == AXIS_X || event_code == MT_POS_X)
                    state_next.acc_x = event_value;
                else if (event_code == AXIS_Y || event_code == MT_POS_Y)
                    state_next.acc_y = event_value;
                else if (event_code == MT_TRACK)
                begin
                    if (event_value == TRACK_RELEASE)
                        state_next.pressed = 1'b0;
                    else if (event_value == TRACK_PRESS)
                        state_next.pressed = 1'b1;
                end
            end
            else if (event_type == EVT_KEY)
            begin
                if (event_code == BUTTON_LEFT || event_code == BUTTON_RIGHT ||
                    event_code == BUTTON_MIDDLE)
                begin
                    if (event_value == LEVEL_UP)
                        state_next.pressed = 1'b0;
                    else if (event_value == LEVEL_DOWN)
                        state_next.pressed = 1'b1;
                    // middle button reports as right
                    state_next.key = (event_code == BUTTON_LEFT) ? KEY_LEFT : KEY_RIGHT;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.acc_x   <= '0;
            state_reg.acc_y   <= '0;
            state_reg.pressed <= 1'b0;
            state_reg.key     <= KEY_NONE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: src/pet_report.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pet_report
// Clamps the tracked position to the area and applies software rotation.
// ---------------------------------------------------------------------------
module pet_report
    import pet_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  track_state_t        state,
    input  logic [CFG_BITS-1:0] area_width,
    input  logic [CFG_BITS-1:0] area_height,
    input  logic [1:0]          rotate_mode,
    output report_t             report
);

    localparam int SW = COORD_BITS + 1;
    localparam int CW = (SW > CFG_BITS) ? SW : CFG_BITS;
    localparam int OW = (COORD_BITS > POINT_BITS) ? COORD_BITS : POINT_BITS;
    localparam logic [CW-1:0] CAP = CW'(1) << COORD_BITS;

    function automatic logic [SW-1:0] size_limit(input logic [CFG_BITS-1:0] s);
        logic [CW-1:0] se;
        se = CW'(s);
        if (se == '0)
            return SW'(1);
        else if (se > CAP)
            return CAP[SW-1:0];
        else
            return se[SW-1:0];
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_pos(input logic [31:0] acc,
                                                        input logic [SW-1:0] size);
        logic [SW-1:0] top;
        top = size - SW'(1);
        if (acc[31])
            return '0;
        else if (acc >= 32'(size))
            return top[COORD_BITS-1:0];
        else
            return acc[COORD_BITS-1:0];
    endfunction

    logic [SW-1:0]         w;
    logic [SW-1:0]         h;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x_mirror;
    logic [COORD_BITS-1:0] y_mirror;
    logic [COORD_BITS-1:0] rx;
    logic [COORD_BITS-1:0] ry;
    logic [SW-1:0]         xm_full;
    logic [SW-1:0]         ym_full;
    logic [OW-1:0]         rx_ext;
    logic [OW-1:0]         ry_ext;

    always_comb
    begin
        w = size_limit(area_width);
        h = size_limit(area_height);
        x = clamp_pos(state.acc_x, w);
        y = clamp_pos(state.acc_y, h);
        xm_full  = w - SW'(1) - SW'(x);
        ym_full  = h - SW'(1) - SW'(y);
        x_mirror = xm_full[COORD_BITS-1:0];
        y_mirror = ym_full[COORD_BITS-1:0];

        unique case (rotate_mode)
            ROT_90:
            begin
                rx = y;
                ry = x_mirror;
            end
            ROT_180:
            begin
                rx = x_mirror;
                ry = y_mirror;
            end
            ROT_270:
            begin
                rx = y_mirror;
                ry = x;
            end
            default:
            begin
                rx = x;
                ry = y;
            end
        endcase

        rx_ext = OW'(rx);
        ry_ext = OW'(ry);
        report.point_x    = rx_ext[POINT_BITS-1:0];
        report.point_y    = ry_ext[POINT_BITS-1:0];
        report.is_pressed = state.pressed;
        report.key_code   = state.key;
    end

endmodule

FILE: src/pointer_event_tracker_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pointer_event_tracker_unit
// Pointer event decoder with clamped, rotated position reports.
// ---------------------------------------------------------------------------
// Path: a report is captured in the input register, then takes one
//   decode/clamp/rotate pass into the output register, which drives out_valid.
// Throughput: one item per cycle, set by the single register-to-register pass,
//   while no report waits in the input register behind an unaccepted result.
// Reset: clears the accumulators, press state and key; config loads 800x480,
//   no rotation. No clearing pass.
// ---------------------------------------------------------------------------
module pointer_event_tracker_unit
    import pet_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_BITS-1:0]   cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  func,
    input  logic [15:0]           event_type,
    input  logic [15:0]           event_code,
    input  logic signed [31:0]    event_value,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [POINT_BITS-1:0] point_x,
    output logic [POINT_BITS-1:0] point_y,
    output logic                  is_pressed,
    output logic [1:0]            key_code
);

    logic [CFG_BITS-1:0] area_width_reg;
    logic [CFG_BITS-1:0] area_height_reg;
    logic [1:0]          rotate_mode_reg;

    logic                s1_valid_reg;
    logic                s1_func_reg;
    logic [15:0]         s1_type_reg;
    logic [15:0]         s1_code_reg;
    logic signed [31:0]  s1_value_reg;

    logic                out_valid_reg;
    report_t             result_reg;

    logic                s1_advance;
    logic                s1_apply;
    track_state_t        state;
    report_t             report;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_width_reg  <= CFG_BITS'(800);
            area_height_reg <= CFG_BITS'(480);
            rotate_mode_reg <= ROT_0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AREA_WIDTH:  area_width_reg  <= cfg_data;
                REG_AREA_HEIGHT: area_height_reg <= cfg_data;
                REG_ROTATE_MODE: rotate_mode_reg <= cfg_data[1:0];
                default:         ;
            endcase
        end
    end

    // events always retire; a report waits for room in the output register
    assign s1_advance = s1_valid_reg && (!s1_func_reg || !out_valid_reg || out_ready);
    assign s1_apply   = s1_advance && !s1_func_reg;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_func_reg  <= func;
            s1_type_reg  <= event_type;
            s1_code_reg  <= event_code;
            s1_value_reg <= event_value;
        end
    end

    pet_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .apply       (s1_apply),
        .event_type  (s1_type_reg),
        .event_code  (s1_code_reg),
        .event_value (s1_value_reg),
        .state       (state)
    );

    pet_report #(
        .COORD_BITS (COORD_BITS)
    ) u_report (
        .state       (state),
        .area_width  (area_width_reg),
        .area_height (area_height_reg),
        .rotate_mode (rotate_mode_reg),
        .report      (report)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance && s1_func_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_func_reg)
            result_reg <= report;
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = result_reg.point_x;
    assign point_y    = result_reg.point_y;
    assign is_pressed = result_reg.is_pressed;
    assign key_code   = result_reg.key_code;

    // a stalled report stays in the input register
    a_report_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_func_reg && out_valid_reg && !out_ready)
        |=> (s1_valid_reg && s1_func_reg))
        else $error("stalled report left the input register");

    // input side only blocks behind a stalled report
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s1_func_reg && out_valid_reg && !out_ready))
        else $error("input blocked without a stalled report");

    // output clears after its transfer unless a report replaces it
    a_out_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ready && !(s1_valid_reg && s1_func_reg)) |=> !out_valid_reg)
        else $error("result repeated after transfer");

    // an event never disturbs a pending result
    a_event_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_func_reg && out_valid_reg && !out_ready)
        |=> (out_valid_reg && $stable(result_reg)))
        else $error("event changed a pending result");

endmodule

FILE: bench/pointer_event_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pointer_event_tracker_unit_tb
// Self-checking bench for the pointer event tracker. A queue-fed driver
// pushes events and report requests, an in-bench tracker predicts every
// report, and a monitor compares the reports field by field under random
// stalls on both channels and across several area and rotation settings.
// ---------------------------------------------------------------------------
module pointer_event_tracker_unit_tb;
    import pet_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_COUNT   = 12;
    localparam int PHASE_EVENTS  = 150;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic        func;
        logic [15:0] evt_type;
        logic [15:0] evt_code;
        logic [31:0] evt_value;
    } pointer_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [1:0]            cfg_index = '0;
    logic [CFG_BITS-1:0]   cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  func = 1'b0;
    logic [15:0]           event_type = '0;
    logic [15:0]           event_code = '0;
    logic signed [31:0]    event_value = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [POINT_BITS-1:0] point_x;
    logic [POINT_BITS-1:0] point_y;
    logic                  is_pressed;
    logic [1:0]            key_code;

    pointer_event_t pending_events[$];
    report_t        expected_reports[$];
    pointer_event_t next_event;

    // tracker copy and register shadow
    logic [31:0]         trk_x = '0;
    logic [31:0]         trk_y = '0;
    logic                trk_pressed = 1'b0;
    logic [1:0]          trk_key = KEY_NONE;
    logic [CFG_BITS-1:0] shadow_width = 13'd800;
    logic [CFG_BITS-1:0] shadow_height = 13'd480;
    logic [1:0]          shadow_rotate = ROT_0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    pointer_event_tracker_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .event_type  (event_type),
        .event_code  (event_code),
        .event_value (event_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .is_pressed  (is_pressed),
        .key_code    (key_code)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("pointer_event_tracker_unit test failed");
            $finish;
        end
    end

    function automatic int fit_size(input logic [CFG_BITS-1:0] s);
        if (s == 0)
            return 1;
        if (s > (1 << POINT_BITS))
            return 1 << POINT_BITS;
        return int'(s);
    endfunction

    function automatic int clamp_axis(input logic [31:0] acc, input int size);
        int v;
        v = $signed(acc);
        if (v < 0)
            return 0;
        if (v >= size)
            return size - 1;
        return v;
    endfunction

    function automatic report_t locate_pointer();
        int      w;
        int      h;
        int      x;
        int      y;
        int      rx;
        int      ry;
        report_t r;
        w = fit_size(shadow_width);
        h = fit_size(shadow_height);
        x = clamp_axis(trk_x, w);
        y = clamp_axis(trk_y, h);
        case (shadow_rotate)
            ROT_90:
            begin
                rx = y;
                ry = w - 1 - x;
            end
            ROT_180:
            begin
                rx = w - 1 - x;
                ry = h - 1 - y;
            end
            ROT_270:
            begin
                rx = h - 1 - y;
                ry = x;
            end
            default:
            begin
                rx = x;
                ry = y;
            end
        endcase
        r.point_x    = rx[POINT_BITS-1:0];
        r.point_y    = ry[POINT_BITS-1:0];
        r.is_pressed = trk_pressed;
        r.key_code   = trk_key;
        return r;
    endfunction

    task automatic advance_tracker(input logic [15:0] t, input logic [15:0] c,
                                   input logic [31:0] v);
        if (t == EVT_REL)
        begin
            if (c == AXIS_X)
                trk_x = trk_x + v;
            else if (c == AXIS_Y)
                trk_y = trk_y + v;
        end
        else if (t == EVT_ABS)
        begin
            if (c == AXIS_X || c == MT_POS_X)
                trk_x = v;
            else if (c == AXIS_Y || c == MT_POS_Y)
                trk_y = v;
            else if (c == MT_TRACK)
            begin
                if (v == TRACK_RELEASE)
                    trk_pressed = 1'b0;
                else if (v == TRACK_PRESS)
                    trk_pressed = 1'b1;
            end
        end
        else if (t == EVT_KEY)
        begin
            if (c == BUTTON_LEFT || c == BUTTON_RIGHT || c == BUTTON_MIDDLE)
            begin
                if (v == LEVEL_UP)
                    trk_pressed = 1'b0;
                else if (v == LEVEL_DOWN)
                    trk_pressed = 1'b1;
                trk_key = (c == BUTTON_LEFT) ? KEY_LEFT : KEY_RIGHT;
            end
        end
    endtask

    // input side: one transfer per accepted item, prediction at the transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            func        <= 1'b0;
            event_type  <= '0;
            event_code  <= '0;
            event_value <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (func)
                    expected_reports.push_back(locate_pointer());
                else
                    advance_tracker(event_type, event_code, event_value);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_event = pending_events.pop_front();
                    in_valid    <= 1'b1;
                    func        <= next_event.func;
                    event_type  <= next_event.evt_type;
                    event_code  <= next_event.evt_code;
                    event_value <= next_event.evt_value;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report transfer with no report pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (point_x !== want.point_x)
                    begin
                        $error("point_x expected %0d got %0d", want.point_x, point_x);
                        mismatches++;
                    end
                    if (point_y !== want.point_y)
                    begin
                        $error("point_y expected %0d got %0d", want.point_y, point_y);
                        mismatches++;
                    end
                    if (is_pressed !== want.is_pressed)
                    begin
                        $error("is_pressed expected %0d got %0d", want.is_pressed,
                               is_pressed);
                        mismatches++;
                    end
                    if (key_code !== want.key_code)
                    begin
                        $error("key_code expected %0d got %0d", want.key_code, key_code);
                        mismatches++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic pointer_event_t make_event(input logic f, input logic [15:0] t,
                                                  input logic [15:0] c,
                                                  input logic [31:0] v);
        pointer_event_t ev;
        ev.func      = f;
        ev.evt_type  = t;
        ev.evt_code  = c;
        ev.evt_value = v;
        return ev;
    endfunction

    function automatic logic [31:0] random_coord();
        int v;
        if ($urandom_range(3) == 0)
            return $urandom();
        v = $urandom_range(4300);
        return v - 100;
    endfunction

    function automatic pointer_event_t random_event();
        int          pick;
        logic [15:0] c;
        logic [31:0] v;
        pick = $urandom_range(99);
        if (pick < 15)
            return make_event(1'b1, 16'($urandom()), 16'($urandom()), $urandom());
        if (pick < 35)
        begin
            c = $urandom_range(1) ? AXIS_X : AXIS_Y;
            if ($urandom_range(7) == 0)
                v = $urandom();
            else
                v = $urandom_range(128) - 64;
            return make_event(1'b0, EVT_REL, c, v);
        end
        if (pick < 55)
        begin
            case ($urandom_range(3))
                0: c = AXIS_X;
                1: c = AXIS_Y;
                2: c = MT_POS_X;
                default: c = MT_POS_Y;
            endcase
            return make_event(1'b0, EVT_ABS, c, random_coord());
        end
        if (pick < 65)
        begin
            case ($urandom_range(2))
                0: v = TRACK_RELEASE;
                1: v = TRACK_PRESS;
                default: v = $urandom();
            endcase
            return make_event(1'b0, EVT_ABS, MT_TRACK, v);
        end
        if (pick < 80)
        begin
            case ($urandom_range(2))
                0: c = BUTTON_LEFT;
                1: c = BUTTON_RIGHT;
                default: c = BUTTON_MIDDLE;
            endcase
            case ($urandom_range(3))
                0, 1: v = LEVEL_DOWN;
                2: v = LEVEL_UP;
                default: v = $urandom();
            endcase
            return make_event(1'b0, EVT_KEY, c, v);
        end
        if (pick < 90)
            return make_event(1'b0, 16'($urandom()), 16'($urandom()), $urandom());
        // known class, mostly unknown code
        case ($urandom_range(2))
            0: c = EVT_KEY;
            1: c = EVT_REL;
            default: c = EVT_ABS;
        endcase
        return make_event(1'b0, c, 16'($urandom_range(16'h013f)), $urandom());
    endfunction

    // waits for the block to go quiet, then lets the pipeline settle
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_area(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                              input logic [1:0] rot);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_AREA_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        cfg_index <= REG_AREA_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        cfg_index <= REG_ROTATE_MODE;
        cfg_data  <= CFG_BITS'(rot);
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_width  = w;
        shadow_height = h;
        shadow_rotate = rot;
    endtask

    initial
    begin
        logic [CFG_BITS-1:0] w;
        logic [CFG_BITS-1:0] h;
        send_idle_pct = 32;
        recv_idle_pct = 71;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass on the reset configuration
        pending_events.push_back(make_event(1'b1, '0, '0, '0));
        pending_events.push_back(make_event(1'b0, EVT_ABS, AXIS_X, 32'h7fff_ffff));
        pending_events.push_back(make_event(1'b0, EVT_ABS, AXIS_Y, 32'h8000_0000));
        pending_events.push_back(make_event(1'b1, '0, '0, '0));
        // both accumulators wrap across the sign boundary
        pending_events.push_back(make_event(1'b0, EVT_REL, AXIS_X, 32'd1));
        pending_events.push_back(make_event(1'b0, EVT_REL, AXIS_Y, 32'hffff_ffff));
        pending_events.push_back(make_event(1'b1, 16'hffff, 16'hffff, 32'hffff_ffff));
        pending_events.push_back(make_event(1'b0, EVT_ABS, MT_POS_X, 32'd100));
        pending_events.push_back(make_event(1'b0, EVT_ABS, MT_POS_Y, 32'd200));
        pending_events.push_back(make_event(1'b0, EVT_ABS, MT_TRACK, TRACK_PRESS));
        pending_events.push_back(make_event(1'b1, '0, '0, '0));
        pending_events.push_back(make_event(1'b0, EVT_ABS, MT_TRACK, 32'd5));
        pending_events.push_back(make_event(1'b0, EVT_KEY, BUTTON_LEFT, LEVEL_DOWN));
        pending_events.push_back(make_event(1'b1, '0, '0, '0));
        // odd level leaves the press state, middle reports as right
        pending_events.push_back(make_event(1'b0, EVT_KEY, BUTTON_MIDDLE, 32'd2));
        pending_events.push_back(make_event(1'b0, EVT_ABS, MT_TRACK, TRACK_RELEASE));
        pending_events.push_back(make_event(1'b1, '0, '0, '0));
        pending_events.push_back(make_event(1'b0, EVT_KEY, BUTTON_RIGHT, LEVEL_UP));
        pending_events.push_back(make_event(1'b0, 16'hffff, AXIS_X, 32'd123));
        pending_events.push_back(make_event(1'b0, 16'h0000, AXIS_Y, 32'd321));
        pending_events.push_back(make_event(1'b0, EVT_ABS, 16'h0002, 32'd9));
        pending_events.push_back(make_event(1'b0, EVT_REL, MT_POS_X, 32'd9));
        pending_events.push_back(make_event(1'b0, EVT_KEY, 16'h0113, LEVEL_DOWN));
        pending_events.push_back(make_event(1'b1, EVT_ABS, AXIS_X, 32'd77));
        wait_quiet();

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p / 4)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 71;
                end
                1:
                begin
                    send_idle_pct = 71;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: write_area(13'd1, 13'd1, ROT_90);
                1: write_area(13'd4096, 13'd4096, ROT_180);
                2: write_area(13'd0, 13'd8191, ROT_270);
                3: write_area(13'd8191, 13'd0, ROT_0);
                default:
                begin
                    w = $urandom_range(1) ? CFG_BITS'($urandom_range(64, 1))
                                          : CFG_BITS'($urandom_range(4096, 1));
                    h = $urandom_range(1) ? CFG_BITS'($urandom_range(64, 1))
                                          : CFG_BITS'($urandom_range(4096, 1));
                    write_area(w, h, 2'(p % 4));
                end
            endcase
            for (int i = 0; i < PHASE_EVENTS; i++)
                pending_events.push_back(random_event());
            wait_quiet();
        end

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("pointer_event_tracker_unit test passed");
        else
            $display("pointer_event_tracker_unit test failed");
        $finish;
    end

endmodule
